// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

   // request operation codes
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [2:0] MODE_POP_BACK   = 3'd2;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [2:0] MODE_DELETE     = 3'd4;
   localparam logic [2:0] MODE_CLEAR      = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int unsigned WORD_WIDTH  = 64;
   localparam int unsigned MODE_WIDTH  = 3;
   localparam int unsigned STAT_WIDTH  = 2;
   localparam int unsigned COUNT_WIDTH = 7;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_DEL_RD,
      STATE_DEL_CHK,
      STATE_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic chk;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_needed;
      logic walk_last;
   } stat_type;

endpackage

// ===== hdl/bdq_ram.sv =====
module bdq_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bdq_ctrl.sv =====
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bdq_pkg::stat_type stat,
   output bdq_pkg::cmd_type  cmd
);

   bdq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::STATE_IDLE: begin
            if (req_valid) begin
               state_in = stat.walk_needed ? bdq_pkg::STATE_DEL_RD : bdq_pkg::STATE_FINISH;
            end
         end
         bdq_pkg::STATE_DEL_RD: begin
            state_in = bdq_pkg::STATE_DEL_CHK;
         end
         bdq_pkg::STATE_DEL_CHK: begin
            state_in = stat.walk_last ? bdq_pkg::STATE_FINISH : bdq_pkg::STATE_DEL_RD;
         end
         bdq_pkg::STATE_FINISH: begin
            if (out_free) begin
               state_in = bdq_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = bdq_pkg::STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         bdq_pkg::STATE_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         bdq_pkg::STATE_DEL_RD: begin
            cmd.rd_issue = 1'b1;
         end
         bdq_pkg::STATE_DEL_CHK: begin
            cmd.chk = 1'b1;
         end
         bdq_pkg::STATE_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/bdq_datapath.sv =====
module bdq_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bdq_pkg::cmd_type                   cmd,
   output bdq_pkg::stat_type                  stat,
   input  logic [bdq_pkg::MODE_WIDTH-1:0]     req_mode,
   input  logic [bdq_pkg::WORD_WIDTH-1:0]     req_value,
   output logic [bdq_pkg::STAT_WIDTH-1:0]     rsp_status,
   output logic [bdq_pkg::COUNT_WIDTH-1:0]    rsp_entry_count,
   output logic [bdq_pkg::COUNT_WIDTH-1:0]    rsp_removed,
   output logic                               mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]        mem_wr_addr,
   output logic [bdq_pkg::WORD_WIDTH-1:0]     mem_wr_data,
   output logic [$clog2(CAPACITY)-1:0]        mem_rd_addr,
   input  logic [bdq_pkg::WORD_WIDTH-1:0]     mem_rd_data
);

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW:0]   CAP_SUM  = (CW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   logic [IW-1:0]                     front_ff, front_in;
   logic [CW-1:0]                     fill_ff, fill_in;
   logic [CW-1:0]                     rd_pos_ff, rd_pos_in;
   logic [CW-1:0]                     wr_pos_ff, wr_pos_in;
   logic [CW-1:0]                     removed_ff, removed_in;
   logic [bdq_pkg::STAT_WIDTH-1:0]    status_ff, status_in;
   logic [bdq_pkg::WORD_WIDTH-1:0]    key_ff, key_in;
   logic [bdq_pkg::STAT_WIDTH-1:0]    out_status_ff;
   logic [bdq_pkg::COUNT_WIDTH-1:0]   out_count_ff, out_removed_ff;
   logic [CW+bdq_pkg::COUNT_WIDTH-1:0] fill_ext, removed_ext;
   logic                              is_full, is_empty, keep;
   logic [IW-1:0]                     front_dec, front_inc;
   logic [CW-1:0]                     rd_pos_nxt;

   // ring slot of a position counted from the front
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                             input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW + 1)'(front) + (CW + 1)'(pos);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[IW-1:0];
   endfunction

   assign is_full    = (fill_ff == CAP_CNT);
   assign is_empty   = (fill_ff == '0);
   assign front_dec  = (front_ff == '0) ? LAST_IDX : front_ff - IW'(1);
   assign front_inc  = (front_ff == LAST_IDX) ? '0 : front_ff + IW'(1);
   assign keep       = (mem_rd_data != key_ff);
   assign rd_pos_nxt = rd_pos_ff + CW'(1);

   assign stat.walk_needed = (req_mode == bdq_pkg::MODE_DELETE) && !is_empty;
   assign stat.walk_last   = (rd_pos_nxt == fill_ff);

   assign mem_rd_addr = slot_of(front_ff, rd_pos_ff);

   always_comb begin
      front_in    = front_ff;
      fill_in     = fill_ff;
      rd_pos_in   = rd_pos_ff;
      wr_pos_in   = wr_pos_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      key_in      = key_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_of(front_ff, wr_pos_ff);
      mem_wr_data = mem_rd_data;

      if (cmd.accept) begin
         status_in  = bdq_pkg::STATUS_OK;
         removed_in = '0;
         rd_pos_in  = '0;
         wr_pos_in  = '0;
         key_in     = req_value;
         case (req_mode)
            bdq_pkg::MODE_PUSH_BACK: begin
               if (is_full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_of(front_ff, fill_ff);
                  mem_wr_data = req_value;
                  fill_in     = fill_ff + CW'(1);
               end
            end
            bdq_pkg::MODE_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = front_dec;
                  mem_wr_data = req_value;
                  front_in    = front_dec;
                  fill_in     = fill_ff + CW'(1);
               end
            end
            bdq_pkg::MODE_POP_BACK: begin
               if (is_empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  fill_in    = fill_ff - CW'(1);
                  removed_in = CW'(1);
               end
            end
            bdq_pkg::MODE_POP_FRONT: begin
               if (is_empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  front_in   = front_inc;
                  fill_in    = fill_ff - CW'(1);
                  removed_in = CW'(1);
               end
            end
            bdq_pkg::MODE_CLEAR: begin
               removed_in = fill_ff;
               fill_in    = '0;
               front_in   = '0;
            end
            default: begin
               status_in = bdq_pkg::STATUS_OK;
            end
         endcase
      end

      // compaction step: kept words slide down to the write position
      if (cmd.chk) begin
         rd_pos_in = rd_pos_nxt;
         if (keep) begin
            mem_wr_en = 1'b1;
            wr_pos_in = wr_pos_ff + CW'(1);
         end else begin
            removed_in = removed_ff + CW'(1);
         end
         if (stat.walk_last) begin
            fill_in = keep ? wr_pos_ff + CW'(1) : wr_pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         fill_ff  <= '0;
      end else begin
         front_ff <= front_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff  <= rd_pos_in;
      wr_pos_ff  <= wr_pos_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      key_ff     <= key_in;
   end

   // counts are reported modulo 128
   assign fill_ext    = (CW + bdq_pkg::COUNT_WIDTH)'(fill_ff);
   assign removed_ext = (CW + bdq_pkg::COUNT_WIDTH)'(removed_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff  <= status_ff;
         out_count_ff   <= fill_ext[bdq_pkg::COUNT_WIDTH-1:0];
         out_removed_ff <= removed_ext[bdq_pkg::COUNT_WIDTH-1:0];
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_removed     = out_removed_ff;

endmodule

// ===== hdl/bounded_deque_with_value_delete_core.sv =====
// Bounded double-ended queue of CAPACITY 64-bit words held in a ring in a
// single-port-read, single-port-write RAM. Every request item (push back,
// push front, pop back, pop front, delete all words equal to value, clear)
// returns exactly one result item with status, entry count after the
// operation and the number of entries removed; both counts are reported
// modulo 128. Items are handled one at a time: for a push, pop, clear or unused
// mode the ring is updated when the item is accepted and the result register
// is loaded in the finish state. Delete value compacts the ring with a walk
// over the held entries, which reads one entry through the registered RAM read
// port and checks and rewrites it in the following cycle. Equality is bitwise.
// The RAM needs no clearing after reset, so the block takes items from the
// first cycle after reset. A new item is taken while the previous result is
// still waiting on a stalled output; it only waits at the result register for
// that slot.
module bounded_deque_with_value_delete_core #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_value,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_entry_count,
   output logic [6:0]  rsp_removed
);

   localparam int unsigned IW = $clog2(CAPACITY);

   bdq_pkg::cmd_type  cmd;
   bdq_pkg::stat_type stat;

   // ring storage connections
   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   logic [63:0]   mem_wr_data;
   logic [IW-1:0] mem_rd_addr;
   logic [63:0]   mem_rd_data;

   // sequencing: idle, walk read, walk check, result hand-off
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pointers, counters, compare and result register
   bdq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_removed     (rsp_removed),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   // entry ring
   bdq_ram #(
      .WIDTH (bdq_pkg::WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // at most one controller command in a cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.rd_issue, cmd.chk, cmd.load_out}))
      else $error("controller issued overlapping commands");

   // every walk read is followed by its check
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |=> cmd.chk)
      else $error("walk read not followed by check");

   // a loaded result shows up on the output
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

   // an accepted item keeps the request side stalled while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous item in progress");

endmodule
